[hw/rtl/ptm_pkg.sv]
// page table manager package: command and status codes, entry bit positions,
// result struct and the level index helper
// no dependencies
`timescale 1ns / 1ps

package ptm_pkg;

    // command codes (any other code is a translate)
    localparam logic [1:0] CMD_MAP       = 2'd0;
    localparam logic [1:0] CMD_UNMAP     = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
    localparam logic [1:0] ST_NO_PAGES   = 2'd2;

    // entry layout
    localparam int PRESENT_BIT  = 0;
    localparam int WRITABLE_BIT = 1;
    localparam int OFFSET_W     = 12;
    localparam int INDEX_W      = 9;
    localparam int ENTRY_W      = 64;
    localparam int VA_W         = 48;
    localparam int PAGE_NUM_W   = ENTRY_W - OFFSET_W;

    // walk levels, root first
    localparam logic [1:0] LEVEL_ROOT = 2'd3;
    localparam logic [1:0] LEVEL_LEAF = 2'd0;

    typedef struct packed {
        logic [1:0]         status;
        logic [ENTRY_W-1:0] addr;
        logic               flush;
    } t_result;

    // table index of the virtual address at one level (shifts 12, 21, 30, 39)
    function automatic logic [INDEX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                       input logic [1:0] level);
        logic [INDEX_W-1:0] idx;
        case (level)
            2'd0: idx = va[20:12];
            2'd1: idx = va[29:21];
            2'd2: idx = va[38:30];
            2'd3: idx = va[47:39];
            default: idx = va[20:12];
        endcase
        return idx;
    endfunction

endpackage

[hw/rtl/four_level_page_table_manager_core.sv]
// four level page table manager top: clearing pass after reset, table
// memory port arbitration and result ports
// depends on ptm_pkg, ptm_ram, ptm_walker
`timescale 1ns / 1ps

// Keeps TABLE_PAGES page tables of 512 64-bit entries in one single port
// memory, page 0 being the root, and serves map, unmap and translate
// transactions. A transaction is taken when start is high and busy is low.
// Each one walks the four levels with a read state and an evaluate state per
// level through the single memory port, and busy stays high until the walk
// ends, at the leaf or at the level where it fails. After reset the block
// zeroes the whole table memory, one entry per cycle over all TABLE_PAGES*512
// entries, with busy held high. Every result is shown for exactly one cycle
// with o_result_valid high and cannot be held off, so the receiver must take
// it in that cycle.
module four_level_page_table_manager_core #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic [ptm_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_phys_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_entry_flags,
    output logic                        o_result_valid,
    output logic [1:0]                  o_status,
    output logic [ptm_pkg::ENTRY_W-1:0] o_translated_addr,
    output logic                        o_flush_request
);

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int ADDR_W = PAGE_W + ptm_pkg::INDEX_W;
    localparam int DEPTH  = TABLE_PAGES * (2 ** ptm_pkg::INDEX_W);

    logic                        r_clearing, n_clearing;
    logic [ADDR_W-1:0]           r_clr_addr, n_clr_addr;
    logic                        walk_busy;
    logic                        walk_we;
    logic [ADDR_W-1:0]           walk_addr;
    logic [ptm_pkg::ENTRY_W-1:0] walk_wdata;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic [ptm_pkg::ENTRY_W-1:0] mem_wdata;
    logic [ptm_pkg::ENTRY_W-1:0] mem_rdata;
    logic                        res_valid;
    ptm_pkg::t_result            res;

    // clearing pass over the whole memory
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // memory port: clearing pass has it until done
    assign mem_we    = r_clearing | walk_we;
    assign mem_addr  = r_clearing ? r_clr_addr : walk_addr;
    assign mem_wdata = r_clearing ? '0 : walk_wdata;

    ptm_ram #(
        .WIDTH (ptm_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    ptm_walker #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start & ~r_clearing),
        .i_command     (i_command),
        .i_virt_addr   (i_virt_addr),
        .i_phys_addr   (i_phys_addr),
        .i_entry_flags (i_entry_flags),
        .o_busy        (walk_busy),
        .o_mem_we      (walk_we),
        .o_mem_addr    (walk_addr),
        .o_mem_wdata   (walk_wdata),
        .i_mem_rdata   (mem_rdata),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // result ports
    assign busy              = r_clearing | walk_busy;
    assign o_result_valid    = res_valid;
    assign o_status          = res.status;
    assign o_translated_addr = res.addr;
    assign o_flush_request   = res.flush;

endmodule

[hw/rtl/ptm_ram.sv]
// generic single port ram with registered read (read before write)
// no dependencies
`timescale 1ns / 1ps

module ptm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ptm_walker.sv]
// page walk sequencer: reads one table entry per level, links new tables from
// the bump allocator, updates the leaf and builds the result
// depends on ptm_pkg
`timescale 1ns / 1ps

module ptm_walker #(
    parameter int TABLE_PAGES = 16,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int ADDR_W = PAGE_W + ptm_pkg::INDEX_W,
    localparam int FREE_W = $clog2(TABLE_PAGES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [1:0]                  i_command,
    input  logic [ptm_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_phys_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_entry_flags,
    output logic                        o_busy,
    output logic                        o_mem_we,
    output logic [ADDR_W-1:0]           o_mem_addr,
    output logic [ptm_pkg::ENTRY_W-1:0] o_mem_wdata,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_mem_rdata,
    output logic                        o_res_valid,
    output ptm_pkg::t_result            o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0]                  r_state, n_state;
    logic [1:0]                  r_level, n_level;
    logic [PAGE_W-1:0]           r_page, n_page;
    logic [FREE_W-1:0]           r_next_free, n_next_free;
    logic [1:0]                  r_cmd;
    logic [ptm_pkg::VA_W-1:0]    r_va;
    logic [ptm_pkg::ENTRY_W-1:0] r_phys;
    logic [ptm_pkg::ENTRY_W-1:0] r_flags;
    logic                        r_res_valid, n_res_valid;
    ptm_pkg::t_result            r_res, n_res;

    logic entry_present;
    logic link_in_range;
    logic pool_empty;
    logic is_map;
    logic is_unmap;

    assign entry_present = i_mem_rdata[ptm_pkg::PRESENT_BIT];
    assign link_in_range = i_mem_rdata[ptm_pkg::ENTRY_W-1:ptm_pkg::OFFSET_W]
                           < ptm_pkg::PAGE_NUM_W'(TABLE_PAGES);
    assign pool_empty    = r_next_free >= FREE_W'(TABLE_PAGES);
    assign is_map        = r_cmd == ptm_pkg::CMD_MAP;
    assign is_unmap      = r_cmd == ptm_pkg::CMD_UNMAP;

    // entry address for the current level
    assign o_mem_addr = {r_page, ptm_pkg::level_index(r_va, r_level)};
    assign o_busy     = r_state != S_IDLE;

    // walk control
    always_comb begin
        n_state     = r_state;
        n_level     = r_level;
        n_page      = r_page;
        n_next_free = r_next_free;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_READ;
                    n_level = ptm_pkg::LEVEL_ROOT;
                    n_page  = '0;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_res.status = ptm_pkg::ST_DONE;
                n_res.addr   = '0;
                n_res.flush  = 1'b0;
                if (r_level != ptm_pkg::LEVEL_LEAF) begin
                    if (entry_present) begin
                        if (link_in_range) begin
                            n_page  = i_mem_rdata[ptm_pkg::OFFSET_W +: PAGE_W];
                            n_level = r_level - 2'd1;
                            n_state = S_READ;
                        end else begin
                            n_res.status = ptm_pkg::ST_NOT_MAPPED;
                            n_res_valid  = 1'b1;
                            n_state      = S_IDLE;
                        end
                    end else if (!is_map) begin
                        n_res.status = ptm_pkg::ST_NOT_MAPPED;
                        n_res_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end else if (pool_empty) begin
                        n_res.status = ptm_pkg::ST_NO_PAGES;
                        n_res_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        // link a fresh table as present and writable
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {{(ptm_pkg::PAGE_NUM_W - PAGE_W){1'b0}},
                                       r_next_free[PAGE_W-1:0],
                                       {(ptm_pkg::OFFSET_W - 2){1'b0}}, 2'b11};
                        n_page      = r_next_free[PAGE_W-1:0];
                        n_next_free = r_next_free + FREE_W'(1);
                        n_level     = r_level - 2'd1;
                        n_state     = S_READ;
                    end
                end else begin
                    // leaf entry
                    n_res_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (is_map) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = {r_phys[ptm_pkg::ENTRY_W-1:ptm_pkg::OFFSET_W],
                                       {ptm_pkg::OFFSET_W{1'b0}}}
                                      | r_flags | ptm_pkg::ENTRY_W'(1);
                        n_res.flush = 1'b1;
                    end else if (!entry_present) begin
                        n_res.status = ptm_pkg::ST_NOT_MAPPED;
                    end else if (is_unmap) begin
                        o_mem_we    = 1'b1;
                        o_mem_wdata = '0;
                        n_res.flush = 1'b1;
                    end else begin
                        n_res.addr = {i_mem_rdata[ptm_pkg::ENTRY_W-1:ptm_pkg::OFFSET_W],
                                      r_va[ptm_pkg::OFFSET_W-1:0]};
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_free <= FREE_W'(1);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_free <= n_next_free;
            r_res_valid <= n_res_valid;
        end
    end

    // request and walk payload registers
    always_ff @(posedge i_clk) begin
        r_level <= n_level;
        r_page  <= n_page;
        r_res   <= n_res;
        if (r_state == S_IDLE && i_start) begin
            r_cmd   <= i_command;
            r_va    <= i_virt_addr;
            r_phys  <= i_phys_addr;
            r_flags <= i_entry_flags;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

[bench/ptm_walk_checker.sv]
// page table manager checker: watches the request and result ports, keeps a
// shadow copy of the table pool and compares every result with its prediction
// depends on ptm_pkg
`timescale 1ns / 1ps

module ptm_walk_checker #(
    parameter int TABLE_PAGES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_command,
    input  logic [ptm_pkg::VA_W-1:0]    i_virt_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_phys_addr,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_entry_flags,
    input  logic                        i_result_valid,
    input  logic [1:0]                  i_status,
    input  logic [ptm_pkg::ENTRY_W-1:0] i_translated_addr,
    input  logic                        i_flush_request,
    output int                          o_fail_count,
    output int                          o_pending
);
    import ptm_pkg::*;

    localparam int TABLE_ENTRIES = 512;

    // shadow of the table pool and its bump allocator
    logic [ENTRY_W-1:0] shadow_tables [0:TABLE_PAGES*TABLE_ENTRIES-1];
    int                 shadow_next_page;
    t_result            pending_results [$];
    int                 mismatches;

    // walk the shadow tables for one transaction, update them, return the result
    function automatic t_result predict_walk_result(input logic [1:0]         cmd,
                                                    input logic [VA_W-1:0]    va,
                                                    input logic [ENTRY_W-1:0] pa,
                                                    input logic [ENTRY_W-1:0] fl);
        t_result            res;
        logic [ENTRY_W-1:0] ent;
        logic [INDEX_W-1:0] idx;
        logic [1:0]         st;
        int                 page;
        int                 slot;
        int                 lvl;
        res  = '0;
        st   = ST_DONE;
        page = 0;
        // intermediate levels, root first
        for (lvl = 3; lvl > 0 && st == ST_DONE; lvl--) begin
            idx  = va[OFFSET_W + INDEX_W*lvl +: INDEX_W];
            slot = page*TABLE_ENTRIES + idx;
            ent  = shadow_tables[slot];
            if (!ent[PRESENT_BIT]) begin
                if (cmd != CMD_MAP) begin
                    st = ST_NOT_MAPPED;
                end else if (shadow_next_page >= TABLE_PAGES) begin
                    st = ST_NO_PAGES;
                end else begin
                    ent = (64'(shadow_next_page) << OFFSET_W) | (64'd1 << PRESENT_BIT)
                        | (64'd1 << WRITABLE_BIT);
                    shadow_tables[slot] = ent;
                    shadow_next_page++;
                end
            end
            if (st == ST_DONE) begin
                // a link past the pool counts as absent
                if (ent[ENTRY_W-1:OFFSET_W] >= PAGE_NUM_W'(TABLE_PAGES))
                    st = ST_NOT_MAPPED;
                else
                    page = int'(ent[ENTRY_W-1:OFFSET_W]);
            end
        end
        // leaf entry
        if (st == ST_DONE) begin
            slot = page*TABLE_ENTRIES + va[OFFSET_W +: INDEX_W];
            ent  = shadow_tables[slot];
            if (cmd == CMD_MAP) begin
                shadow_tables[slot] = {pa[ENTRY_W-1:OFFSET_W], {OFFSET_W{1'b0}}} | fl
                                    | (64'd1 << PRESENT_BIT);
                res.flush = 1'b1;
            end else if (!ent[PRESENT_BIT]) begin
                st = ST_NOT_MAPPED;
            end else if (cmd == CMD_UNMAP) begin
                shadow_tables[slot] = '0;
                res.flush = 1'b1;
            end else begin
                res.addr = {ent[ENTRY_W-1:OFFSET_W], va[OFFSET_W-1:0]};
            end
        end
        res.status = st;
        return res;
    endfunction

    // predict on each accepted transaction, compare each result with the oldest
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            foreach (shadow_tables[i]) shadow_tables[i] = '0;
            shadow_next_page = 1;
            pending_results.delete();
            mismatches = 0;
        end else begin
            if (i_start && !i_busy)
                pending_results.push_back(predict_walk_result(i_command, i_virt_addr,
                                                              i_phys_addr, i_entry_flags));
            if (i_result_valid) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction outstanding: status %0d addr %h",
                           i_status, i_translated_addr);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        mismatches++;
                    end
                    if (i_translated_addr !== want.addr) begin
                        $error("translated_addr: expected %h, actual %h",
                               want.addr, i_translated_addr);
                        mismatches++;
                    end
                    if (i_flush_request !== want.flush) begin
                        $error("flush_request: expected %0d, actual %0d",
                               want.flush, i_flush_request);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= pending_results.size();
        o_fail_count <= mismatches;
    end

endmodule

[bench/four_level_page_table_manager_core_tb.sv]
// page table manager testbench top: clock, reset, directed and random
// map/unmap/translate transactions, timeout and verdict
// depends on ptm_pkg, four_level_page_table_manager_core, ptm_walk_checker
`timescale 1ns / 1ps

module four_level_page_table_manager_core_tb;
    import ptm_pkg::*;

    localparam int  TABLE_PAGES   = 16;
    localparam int  RANDOM_ITEMS  = 333;
    localparam int  LIMIT_CYCLES  = 600000;
    localparam int  TAIL_CYCLES   = 20;

    // addresses for the directed part
    localparam logic [VA_W-1:0] VA_LOW      = 48'h0000_0000_1000;
    localparam logic [VA_W-1:0] VA_TOP      = 48'hFFFF_FFFF_FFFF;
    localparam logic [VA_W-1:0] VA_TOP_L2   = 48'hFF80_0000_0000;
    localparam logic [VA_W-1:0] VA_ROOT_ONE = 48'h0080_0000_0000;
    localparam logic [VA_W-1:0] VA_ROOT_TWO = 48'h0100_0000_0000;
    localparam logic [VA_W-1:0] VA_ROOT_SIX = 48'h0300_0000_0000;
    localparam logic [VA_W-1:0] VA_SPLIT    = 48'h0000_4000_0000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_command;
    logic [VA_W-1:0]     i_virt_addr;
    logic [ENTRY_W-1:0]  i_phys_addr;
    logic [ENTRY_W-1:0]  i_entry_flags;
    logic                o_result_valid;
    logic [1:0]          o_status;
    logic [ENTRY_W-1:0]  o_translated_addr;
    logic                o_flush_request;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;

    // leaf tables known to exist once the directed part has run
    logic [VA_W-1:0]     leaf_bases [0:4];
    int                  idle_pct [0:3];

    four_level_page_table_manager_core #(
        .TABLE_PAGES(TABLE_PAGES)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_command        (i_command),
        .i_virt_addr      (i_virt_addr),
        .i_phys_addr      (i_phys_addr),
        .i_entry_flags    (i_entry_flags),
        .o_result_valid   (o_result_valid),
        .o_status         (o_status),
        .o_translated_addr(o_translated_addr),
        .o_flush_request  (o_flush_request)
    );

    ptm_walk_checker #(
        .TABLE_PAGES(TABLE_PAGES)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_command        (i_command),
        .i_virt_addr      (i_virt_addr),
        .i_phys_addr      (i_phys_addr),
        .i_entry_flags    (i_entry_flags),
        .i_result_valid   (o_result_valid),
        .i_status         (o_status),
        .i_translated_addr(o_translated_addr),
        .i_flush_request  (o_flush_request),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // one transaction: hold start until accepted, then maybe go idle
    task automatic issue_request(input logic [1:0]         cmd,
                                 input logic [VA_W-1:0]    va,
                                 input logic [ENTRY_W-1:0] pa,
                                 input logic [ENTRY_W-1:0] fl,
                                 input int                 idle);
        start         <= 1'b1;
        i_command     <= cmd;
        i_virt_addr   <= va;
        i_phys_addr   <= pa;
        i_entry_flags <= fl;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle);
        end
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [ENTRY_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // mostly addresses inside existing leaf tables, a few anywhere
    function automatic logic [VA_W-1:0] pick_address();
        logic [VA_W-1:0] va;
        int              roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            va = {16'($urandom), $urandom};
        end else begin
            va = leaf_bases[$urandom_range(4)];
            va[20:12] = (roll < 75) ? 9'($urandom_range(7)) : 9'($urandom);
            va[11:0]  = 12'($urandom);
        end
        return va;
    endfunction

    function automatic logic [1:0] pick_command();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35)      return CMD_MAP;
        else if (roll < 60) return CMD_UNMAP;
        else if (roll < 95) return CMD_TRANSLATE;
        else                return 2'd3;
    endfunction

    // stimulus and verdict
    initial begin
        leaf_bases[0] = VA_LOW;
        leaf_bases[1] = VA_TOP;
        leaf_bases[2] = VA_TOP_L2;
        leaf_bases[3] = VA_ROOT_ONE;
        leaf_bases[4] = VA_ROOT_TWO;
        idle_pct[0] = 0;
        idle_pct[1] = 81;
        idle_pct[2] = 0;
        idle_pct[3] = 30;

        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_command     <= CMD_TRANSLATE;
        i_virt_addr   <= '0;
        i_phys_addr   <= '0;
        i_entry_flags <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty tables, overwrite, unmap twice, command three
        issue_request(CMD_TRANSLATE, VA_LOW, '0, '0, 0);
        issue_request(CMD_UNMAP, VA_LOW, '0, '0, 0);
        issue_request(CMD_MAP, VA_LOW, '1, '0, 0);
        issue_request(CMD_TRANSLATE, VA_LOW | 48'hABC, '0, '0, 0);
        issue_request(CMD_MAP, VA_LOW, '0, 64'h8000_0000_0000_0000, 0);
        issue_request(2'd3, VA_LOW | 48'hFFF, '0, '0, 0);
        issue_request(CMD_UNMAP, VA_LOW, '0, '0, 0);
        issue_request(CMD_UNMAP, VA_LOW, '0, '0, 0);
        issue_request(CMD_TRANSLATE, VA_LOW, '0, '0, 0);
        issue_request(CMD_MAP, VA_LOW, 64'h0123_4567_89AB_CDEF, 64'h0000_0000_0000_0FFE, 0);
        // all-ones address and flags, then shared upper levels
        issue_request(CMD_MAP, VA_TOP, 64'hDEAD_BEEF_CAFE_F00D, '1, 0);
        issue_request(CMD_TRANSLATE, VA_TOP, '0, '0, 0);
        issue_request(CMD_MAP, VA_TOP_L2, random_word(), 64'h2, 0);
        issue_request(CMD_MAP, VA_ROOT_ONE, random_word(), '0, 0);
        issue_request(CMD_MAP, VA_ROOT_TWO, random_word(), '0, 0);
        // pool runs out part way down the walk; the partial link stays
        issue_request(CMD_MAP, VA_SPLIT, random_word(), '0, 0);
        issue_request(CMD_TRANSLATE, VA_SPLIT, '0, '0, 0);
        issue_request(CMD_UNMAP, VA_SPLIT, '0, '0, 0);
        issue_request(CMD_MAP, VA_ROOT_SIX, random_word(), '0, 0);
        issue_request(CMD_MAP, VA_LOW | 48'h2000, random_word(), random_word(), 0);
        issue_request(CMD_TRANSLATE, VA_LOW | 48'h2123, '0, '0, 0);
        drain_results();

        // random phases with varied sender idling
        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < RANDOM_ITEMS; n++)
                issue_request(pick_command(), pick_address(), random_word(),
                              ($urandom_range(1) != 0) ? random_word()
                                                       : ENTRY_W'($urandom_range(4095)),
                              idle_pct[ph]);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
